// File: sv/sfcp_pkg.sv
// Shared types and constants for the servo frame checksum parser.
// Used by the front parser, the job queue, the emitter and the top level.
package sfcp_pkg;

  // Header bytes
  localparam logic [7:0] HDR_SYNC_FIXED = 8'hFF;
  localparam logic [7:0] HDR_TAIL_FIXED = 8'hEE;
  localparam logic [7:0] HDR_SYNC_LONG  = 8'hFE;
  localparam logic [7:0] HDR_TAIL_LONG  = 8'hEF;

  // Channel count implied by the fixed header
  localparam int FIXED_COUNT = 8;

  // Count and index widths cover up to 64 channels; CH_W only up to 31
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;
  localparam int PW_W  = 16;
  localparam int CH_W  = 5;

  // Width buffer write from the front parser
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [PW_W-1:0]  data;
  } wr_t;

  // One checked frame waiting for emission
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } job_t;

endpackage

// File: sv/sfcp_front.sv
// Front parser: header, count, payload and Fletcher check for each chunk.
// Writes widths into one bank of the buffer and posts a job per good frame.
// Depends on sfcp_pkg.
module sfcp_front #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              chunk_start,
  output logic              in_payload,
  output sfcp_pkg::wr_t     wr,
  output logic              job_push,
  output sfcp_pkg::job_t    job
);
  import sfcp_pkg::*;

  localparam logic FIXED_OK = (FIXED_COUNT <= MAX_CHANNELS);
  localparam logic [7:0] MAX_BYTE = 8'(MAX_CHANNELS);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR2, PH_COUNT, PH_PAYLOAD, PH_CKA, PH_CKB
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             long_r, long_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             half_r, half_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic             bank_r, bank_nxt;
  logic [7:0]       sum_a_add;
  logic             last_byte;

  assign in_payload = (phase_r == PH_PAYLOAD);
  assign sum_a_add  = sum_a_r + data_byte;
  assign last_byte  = half_r && (({1'b0, idx_r} + 7'd1) == count_r);

  // Compute the next parser state for one transfer
  always_comb begin
    phase_nxt = phase_r;
    long_nxt  = long_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    half_nxt  = half_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    hi_nxt    = hi_r;
    bank_nxt  = bank_r;
    wr        = '0;
    wr.bank   = bank_r;
    wr.idx    = idx_r;
    wr.data   = {hi_r, data_byte};
    job_push  = 1'b0;
    job.bank  = bank_r;
    job.count = count_r;
    if (fire) begin
      if (chunk_start) begin
        sum_a_nxt = '0;
        sum_b_nxt = '0;
        idx_nxt   = '0;
        half_nxt  = 1'b0;
        if (data_byte == HDR_SYNC_FIXED) begin
          long_nxt  = 1'b0;
          phase_nxt = PH_HDR2;
        end else if (data_byte == HDR_SYNC_LONG) begin
          long_nxt  = 1'b1;
          phase_nxt = PH_HDR2;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end else begin
        case (phase_r)
          PH_HDR2: begin
            if (long_r) begin
              phase_nxt = (data_byte == HDR_TAIL_LONG) ? PH_COUNT : PH_IDLE;
            end else if (data_byte == HDR_TAIL_FIXED && FIXED_OK) begin
              count_nxt = CNT_W'(FIXED_COUNT);
              idx_nxt   = '0;
              half_nxt  = 1'b0;
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_COUNT: begin
            if (data_byte == 8'd0 || data_byte > MAX_BYTE) begin
              phase_nxt = PH_IDLE;
            end else begin
              count_nxt = data_byte[CNT_W-1:0];
              idx_nxt   = '0;
              half_nxt  = 1'b0;
              phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            sum_a_nxt = sum_a_add;
            sum_b_nxt = sum_b_r + sum_a_add;
            if (!half_r) begin
              hi_nxt   = data_byte;
              half_nxt = 1'b1;
            end else begin
              wr.en    = 1'b1;
              half_nxt = 1'b0;
              idx_nxt  = idx_r + 6'd1;
              if (last_byte) phase_nxt = PH_CKA;
            end
          end
          PH_CKA: begin
            phase_nxt = (data_byte == sum_a_r) ? PH_CKB : PH_IDLE;
          end
          PH_CKB: begin
            phase_nxt = PH_IDLE;
            // Post the frame and move on to the other bank
            if (data_byte == sum_b_r) begin
              job_push = 1'b1;
              bank_nxt = ~bank_r;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      long_r  <= 1'b0;
      count_r <= '0;
      idx_r   <= '0;
      half_r  <= 1'b0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      hi_r    <= '0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      long_r  <= long_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      half_r  <= half_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      hi_r    <= hi_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

// File: sv/sfcp_jobq.sv
// Two-entry queue of checked frames between the parser and the emitter.
// Depends on sfcp_pkg.
module sfcp_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfcp_pkg::job_t  push_job,
  input  logic            pop,
  output logic            head_valid,
  output logic            full,
  output sfcp_pkg::job_t  head
);
  import sfcp_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head_valid = (cnt_r != 2'd0);
  assign full       = (cnt_r == 2'd2);
  assign head       = ent_r[rp_r];

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

endmodule

// File: sv/sfcp_back.sv
// Emitter: two-bank width buffer, registered read and output register.
// Reads one channel per cycle for the head job unless the output stalls.
// Depends on sfcp_pkg.
module sfcp_back #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sfcp_pkg::wr_t              wr,
  input  logic                       job_valid,
  input  sfcp_pkg::job_t             job,
  output logic                       job_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sfcp_pkg::CH_W-1:0]  out_channel_number,
  output logic [sfcp_pkg::PW_W-1:0]  out_pulse_width,
  output logic                       out_last_channel
);
  import sfcp_pkg::*;

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [PW_W-1:0]  mem_r [2][MAX_CHANNELS];
  logic [IDX_W-1:0] iss_r, iss_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  logic [PW_W-1:0]  rd_data_r;
  logic [CH_W-1:0]  rd_chan_r;
  logic             rd_last_r;
  logic             out_valid_r, out_valid_nxt;
  logic [PW_W-1:0]  out_pw_r;
  logic [CH_W-1:0]  out_chan_r;
  logic             out_last_r;
  logic             move, issue, iss_last;
  logic [CNT_W-1:0] iss_plus;

  assign move     = rd_valid_r && (!out_valid_r || !out_stall);
  assign issue    = job_valid && (!rd_valid_r || move);
  assign iss_plus = {1'b0, iss_r} + 7'd1;
  assign iss_last = (iss_plus == job.count);
  assign job_pop  = issue && iss_last;

  assign out_valid          = out_valid_r;
  assign out_channel_number = out_chan_r;
  assign out_pulse_width    = out_pw_r;
  assign out_last_channel   = out_last_r;

  // Advance read index and stage flags
  always_comb begin
    iss_nxt = iss_r;
    if (issue) iss_nxt = iss_last ? '0 : iss_r + 6'd1;
    rd_valid_nxt  = issue || (rd_valid_r && !move);
    out_valid_nxt = move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      iss_r       <= iss_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Write widths from the parser; banks in use by a job are never written
  always_ff @(posedge clk) begin
    if (wr.en) mem_r[wr.bank][wr.idx[IW-1:0]] <= wr.data;
  end

  // Registered read; data holds until moved to the output
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem_r[job.bank][iss_r[IW-1:0]];
      rd_chan_r <= iss_plus[CH_W-1:0];
      rd_last_r <= iss_last;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_pw_r   <= rd_data_r;
      out_chan_r <= rd_chan_r;
      out_last_r <= rd_last_r;
    end
  end

endmodule

// File: sv/servo_frame_checksum_parser.sv
// Servo frame parser with 8-bit Fletcher checksum over the payload.
// Usage:
//   Input channel (in_valid / in_stall): one received byte per transfer,
//   in_chunk_start high on the first byte of each read chunk. Each chunk is
//   parsed as one frame: FF EE (eight channels) or FE EF plus a count byte,
//   big-endian widths, then checksum bytes A and B.
//   Result channel (out_valid / out_stall): one transfer per channel of a
//   good frame, channel numbers from 1, last channel flagged.
// Timing:
//   Bytes are taken one per cycle unless in_stall is high. After the checksum
//   B byte of a frame, with no earlier frame being emitted, its results pass the
//   read and output registers, one result per cycle unless the receiver stalls.
//   The width buffer has two banks, and the job queue holds two frames; the
//   parser stalls its payload bytes while both banks wait for emission.
//   A stall on the result side holds the output and, behind it, the read
//   stage; the parser keeps going until it needs a busy bank.
// Reset: synchronous, active low; clears the parser, queue and output valid.
//   The width buffer is not cleared: every entry is written before it is read.
// Depends on sfcp_pkg, sfcp_front, sfcp_jobq, sfcp_back.
module servo_frame_checksum_parser #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_chunk_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sfcp_pkg::CH_W-1:0]  out_channel_number,
  output logic [sfcp_pkg::PW_W-1:0]  out_pulse_width,
  output logic                       out_last_channel
);
  import sfcp_pkg::*;

  logic in_fire, in_payload, job_push, job_pop, q_valid, q_full;
  wr_t  wr;
  job_t push_job, head_job;

  // Hold payload bytes while both buffer banks wait for emission
  assign in_stall = q_full && in_payload;
  assign in_fire  = in_valid && !in_stall;

  sfcp_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .data_byte   (in_data_byte),
    .chunk_start (in_chunk_start),
    .in_payload  (in_payload),
    .wr          (wr),
    .job_push    (job_push),
    .job         (push_job)
  );

  sfcp_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_valid (q_valid),
    .full       (q_full),
    .head       (head_job)
  );

  sfcp_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .wr                 (wr),
    .job_valid          (q_valid),
    .job                (head_job),
    .job_pop            (job_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_number (out_channel_number),
    .out_pulse_width    (out_pulse_width),
    .out_last_channel   (out_last_channel)
  );

endmodule
